[hdl/kls_pkg.sv]
// Package for the keyframe linear sampler.
// Holds field widths, input mode codes and the controller/datapath interface structs.
// No dependencies.
package kls_pkg;

    localparam int TIME_W    = 24;
    localparam int VAL_W     = 32;
    localparam int KC_W      = 7;
    localparam int IDX_W     = 6;
    localparam int FRAC_BITS = 16;
    localparam int DIV_CNT_W = $clog2(FRAC_BITS);

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef struct packed {
        logic load_key;
        logic start;
        logic next;
        logic pick_first;
        logic pick_seg;
        logic pick_last;
        logic flag;
        logic div_start;
        logic div_step;
        logic rd_k1;
        logic cap_start;
        logic cap_diff;
        logic mult;
        logic load_out;
    } kls_cmd_t;

    typedef struct packed {
        logic n_one;
        logic t_lt;
        logic idx_zero;
        logic idx_last;
        logic seg_div;
        logic div_done;
        logic out_full;
    } kls_stat_t;

endpackage

[hdl/keyframe_linear_sampler.sv]
// Keyframe linear sampler: holds up to MAX_KEYS keys (time and xyz vector) and
// interpolates linearly between neighboring keys at a requested time.
// Built from kls_ctrl and kls_datapath; depends on kls_pkg.
//
// The input channel carries two kinds of transaction. A load (s_mode low)
// writes one key at s_key_index in the accepting cycle and returns nothing.
// A sample (s_mode high) returns one transaction on the result channel with
// the blended vector, the starting key index and an out-of-range flag.
// The key count register is written through cfg_wr_en and cfg_wr_data; the
// user must write it only while the block is idle, as the block itself does
// not enforce this. A sample reads the keys in turn through the single read
// port of the key memory until it finds its segment or reaches the last key,
// then, when the factor must be divided out, runs the one-bit-per-cycle
// restoring divider before the blend.
// One sample is in work at a time; s_ready is high only while no sample is.
// A finished result waits in the output register while the next transaction
// is accepted; if the receiver stalls, a second result waits inside the
// block until the register frees. Reset empties the output register, returns
// the key count to one and leaves the key memories as they were.
module keyframe_linear_sampler
    import kls_pkg::*;
#(
    parameter int MAX_KEYS = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [KC_W-1:0]          cfg_wr_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_mode,
    input  logic [IDX_W-1:0]         s_key_index,
    input  logic [TIME_W-1:0]        s_time_ticks,
    input  logic signed [VAL_W-1:0]  s_value_x,
    input  logic signed [VAL_W-1:0]  s_value_y,
    input  logic signed [VAL_W-1:0]  s_value_z,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [VAL_W-1:0]  m_out_x,
    output logic signed [VAL_W-1:0]  m_out_y,
    output logic signed [VAL_W-1:0]  m_out_z,
    output logic [IDX_W-1:0]         m_segment_index,
    output logic                     m_out_of_range
);

    kls_cmd_t  cmd;
    kls_stat_t stat;

    kls_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_mode),
        .s_ready (s_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    kls_datapath #(
        .MAX_KEYS (MAX_KEYS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_key_index     (s_key_index),
        .s_time_ticks    (s_time_ticks),
        .s_value_x       (s_value_x),
        .s_value_y       (s_value_y),
        .s_value_z       (s_value_z),
        .cmd             (cmd),
        .stat            (stat),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_x         (m_out_x),
        .m_out_y         (m_out_y),
        .m_out_z         (m_out_z),
        .m_segment_index (m_segment_index),
        .m_out_of_range  (m_out_of_range)
    );

endmodule

[hdl/kls_ctrl.sv]
// Controller state machine of the keyframe linear sampler.
// Sequences the key scan, the division and the vector blend; depends on kls_pkg.
module kls_ctrl
    import kls_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_mode,
    output logic      s_ready,
    output kls_cmd_t  cmd,
    input  kls_stat_t stat
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_CMP,
        ST_DIV,
        ST_VRD0,
        ST_VCAP0,
        ST_VCAP1,
        ST_MUL,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_mode == MODE_SAMPLE) begin
                        cmd.start  = 1'b1;
                        state_next = ST_RD;
                    end else begin
                        cmd.load_key = 1'b1;
                    end
                end
            end
            ST_RD: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (stat.n_one) begin
                    cmd.pick_first = 1'b1;
                    state_next     = ST_VRD0;
                end else if (stat.idx_zero && stat.t_lt) begin
                    cmd.pick_first = 1'b1;
                    cmd.flag       = 1'b1;
                    state_next     = ST_VRD0;
                end else if (stat.t_lt) begin
                    cmd.pick_seg = 1'b1;
                    if (stat.seg_div) begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end else begin
                        state_next = ST_VRD0;
                    end
                end else if (stat.idx_last) begin
                    cmd.pick_last = 1'b1;
                    cmd.flag      = 1'b1;
                    state_next    = ST_VRD0;
                end else begin
                    cmd.next   = 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) begin
                    state_next = ST_VRD0;
                end
            end
            ST_VRD0: begin
                cmd.rd_k1  = 1'b1;
                state_next = ST_VCAP0;
            end
            ST_VCAP0: begin
                cmd.cap_start = 1'b1;
                state_next    = ST_VCAP1;
            end
            ST_VCAP1: begin
                cmd.cap_diff = 1'b1;
                state_next   = ST_MUL;
            end
            ST_MUL: begin
                cmd.mult   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!stat.out_full) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[hdl/kls_datapath.sv]
// Datapath of the keyframe linear sampler: key memories, scan registers,
// restoring divider, blend multipliers and output register; depends on kls_pkg.
module kls_datapath
    import kls_pkg::*;
#(
    parameter int MAX_KEYS = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [KC_W-1:0]          cfg_wr_data,
    input  logic [IDX_W-1:0]         s_key_index,
    input  logic [TIME_W-1:0]        s_time_ticks,
    input  logic signed [VAL_W-1:0]  s_value_x,
    input  logic signed [VAL_W-1:0]  s_value_y,
    input  logic signed [VAL_W-1:0]  s_value_z,
    input  kls_cmd_t                 cmd,
    output kls_stat_t                stat,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [VAL_W-1:0]  m_out_x,
    output logic signed [VAL_W-1:0]  m_out_y,
    output logic signed [VAL_W-1:0]  m_out_z,
    output logic [IDX_W-1:0]         m_segment_index,
    output logic                     m_out_of_range
);

    localparam int AW    = $clog2(MAX_KEYS);
    localparam int SEGW  = (AW > IDX_W) ? AW : IDX_W;
    localparam int DW    = VAL_W + 1;
    localparam int PW    = DW + FRAC_BITS + 1;

    logic [TIME_W-1:0] time_mem [MAX_KEYS];
    logic [VAL_W-1:0]  x_mem    [MAX_KEYS];
    logic [VAL_W-1:0]  y_mem    [MAX_KEYS];
    logic [VAL_W-1:0]  z_mem    [MAX_KEYS];

    logic [TIME_W-1:0] time_q;
    logic [VAL_W-1:0]  x_q;
    logic [VAL_W-1:0]  y_q;
    logic [VAL_W-1:0]  z_q;

    logic [KC_W-1:0]      key_count_reg;
    logic [AW-1:0]        addr_reg;
    logic [AW-1:0]        k1_reg;
    logic [AW-1:0]        last_reg;
    logic [AW-1:0]        last_next;
    logic [AW-1:0]        seg_reg;
    logic                 flag_reg;
    logic [TIME_W-1:0]    t_reg;
    logic [TIME_W-1:0]    prev_reg;
    logic [TIME_W-1:0]    rem_reg;
    logic [TIME_W-1:0]    den_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [FRAC_BITS-1:0] frac_reg;
    logic [TIME_W:0]      rem_shift;
    logic                 rem_ge;
    logic [TIME_W-1:0]    rem_next;

    logic [VAL_W-1:0]     ax_reg, ay_reg, az_reg;
    logic signed [DW-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [PW-1:0] px_reg, py_reg, pz_reg;
    logic signed [FRAC_BITS:0] frac_s;

    logic [VAL_W-1:0]  out_x_reg, out_y_reg, out_z_reg;
    logic [IDX_W-1:0]  out_seg_reg;
    logic              out_flag_reg;
    logic              m_valid_reg;
    logic [SEGW-1:0]   seg_wide;
    logic              wr_ok;
    logic [AW-1:0]     wr_addr;

    assign wr_ok   = cmd.load_key && (int'(s_key_index) < MAX_KEYS);
    assign wr_addr = AW'(s_key_index);

    // Key memories: one write port for load transactions, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            time_mem[wr_addr] <= s_time_ticks;
        end
        time_q <= time_mem[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            x_mem[wr_addr] <= s_value_x;
        end
        x_q <= x_mem[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            y_mem[wr_addr] <= s_value_y;
        end
        y_q <= y_mem[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            z_mem[wr_addr] <= s_value_z;
        end
        z_q <= z_mem[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_count_reg <= KC_W'(1);
        end else if (cfg_wr_en) begin
            key_count_reg <= cfg_wr_data;
        end
    end

    // The last usable key index, with a zero count read as one key and a count above MAX_KEYS read as MAX_KEYS.
    always_comb begin
        if (key_count_reg == '0) begin
            last_next = '0;
        end else if (int'(key_count_reg) > MAX_KEYS) begin
            last_next = AW'(MAX_KEYS - 1);
        end else begin
            last_next = AW'(key_count_reg - KC_W'(1));
        end
    end

    assign stat.n_one    = (last_reg == '0);
    assign stat.t_lt     = (t_reg < time_q);
    assign stat.idx_zero = (addr_reg == '0);
    assign stat.idx_last = (addr_reg == last_reg);
    assign stat.seg_div  = (t_reg >= prev_reg) && (time_q > prev_reg);
    assign stat.div_done = (div_cnt_reg == '1);
    assign stat.out_full = m_valid_reg && !m_ready;

    assign rem_shift = {rem_reg, 1'b0};
    assign rem_ge    = (rem_shift >= {1'b0, den_reg});
    assign rem_next  = rem_ge ? TIME_W'(rem_shift - {1'b0, den_reg}) : rem_shift[TIME_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            t_reg    <= s_time_ticks;
            last_reg <= last_next;
            addr_reg <= '0;
        end
        if (cmd.next) begin
            prev_reg <= time_q;
            addr_reg <= addr_reg + AW'(1);
        end
        if (cmd.pick_first) begin
            addr_reg <= '0;
            k1_reg   <= '0;
            seg_reg  <= '0;
            flag_reg <= cmd.flag;
            frac_reg <= '0;
        end
        if (cmd.pick_seg) begin
            addr_reg <= addr_reg - AW'(1);
            k1_reg   <= addr_reg;
            seg_reg  <= addr_reg - AW'(1);
            flag_reg <= 1'b0;
            frac_reg <= '0;
        end
        if (cmd.pick_last) begin
            k1_reg   <= addr_reg;
            seg_reg  <= addr_reg;
            flag_reg <= cmd.flag;
            frac_reg <= '0;
        end
        if (cmd.div_start) begin
            rem_reg     <= t_reg - prev_reg;
            den_reg     <= time_q - prev_reg;
            div_cnt_reg <= '0;
        end
        if (cmd.div_step) begin
            rem_reg     <= rem_next;
            frac_reg    <= {frac_reg[FRAC_BITS-2:0], rem_ge};
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
        if (cmd.rd_k1) begin
            addr_reg <= k1_reg;
        end
    end

    assign frac_s = $signed({1'b0, frac_reg});

    always_ff @(posedge aclk) begin
        if (cmd.cap_start) begin
            ax_reg <= x_q;
            ay_reg <= y_q;
            az_reg <= z_q;
        end
        if (cmd.cap_diff) begin
            dx_reg <= $signed({x_q[VAL_W-1], x_q}) - $signed({ax_reg[VAL_W-1], ax_reg});
            dy_reg <= $signed({y_q[VAL_W-1], y_q}) - $signed({ay_reg[VAL_W-1], ay_reg});
            dz_reg <= $signed({z_q[VAL_W-1], z_q}) - $signed({az_reg[VAL_W-1], az_reg});
        end
        if (cmd.mult) begin
            px_reg <= PW'(dx_reg * frac_s);
            py_reg <= PW'(dy_reg * frac_s);
            pz_reg <= PW'(dz_reg * frac_s);
        end
    end

    assign seg_wide = SEGW'(seg_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_x_reg    <= ax_reg + px_reg[FRAC_BITS+VAL_W-1:FRAC_BITS];
            out_y_reg    <= ay_reg + py_reg[FRAC_BITS+VAL_W-1:FRAC_BITS];
            out_z_reg    <= az_reg + pz_reg[FRAC_BITS+VAL_W-1:FRAC_BITS];
            out_seg_reg  <= seg_wide[IDX_W-1:0];
            out_flag_reg <= flag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_x         = out_x_reg;
    assign m_out_y         = out_y_reg;
    assign m_out_z         = out_z_reg;
    assign m_segment_index = out_seg_reg;
    assign m_out_of_range  = out_flag_reg;

endmodule
